/* rtl/rjp_pkg.sv */
// Package for the RTP/JPEG packetizer: constants, register indexes and field widths.
// Used by the channel interfaces and by rtp_jpeg_packetizer; depends on nothing.
package rjp_pkg;

	localparam int FRAGMENT_BYTES = 1438;

	localparam int DATA_W    = 8;
	localparam int FRAME_W   = 24;
	localparam int ELAPSED_W = 16;
	localparam int SEQ_W     = 16;
	localparam int TS_W      = 32;
	localparam int CFG_W     = 32;
	localparam int DIM_W     = 11;
	localparam int HIDX_W    = 5;

	localparam logic [7:0] IL_MAGIC     = 8'h24;
	localparam logic [7:0] RTP_VERSION  = 8'h80;
	localparam logic [7:0] RTP_PT_JPEG  = 8'h1a;
	localparam logic [7:0] RTP_MARKER   = 8'h80;
	localparam logic [6:0] TS_PER_MS    = 7'd90;
	localparam int         HDR_BYTES    = 20;

	localparam logic [HIDX_W-1:0] HIDX_IL_FIRST  = 5'd0;
	localparam logic [HIDX_W-1:0] HIDX_RTP_FIRST = 5'd4;
	localparam logic [HIDX_W-1:0] HIDX_LAST      = 5'd23;

	typedef enum logic [2:0] {
		REG_INTERLEAVED = 3'd0,
		REG_CHANNEL     = 3'd1,
		REG_SOURCE      = 3'd2,
		REG_QUALITY     = 3'd3,
		REG_WIDTH       = 3'd4,
		REG_HEIGHT      = 3'd5
	} reg_index_t;

endpackage

/* rtl/rjp_frame_if.sv */
// Valid/ready channel carrying JPEG frame bytes into the packetizer.
// Depends on rjp_pkg for the field widths.
interface rjp_frame_if;
	logic                          valid;
	logic                          ready;
	logic [rjp_pkg::DATA_W-1:0]    data_byte;
	logic [rjp_pkg::FRAME_W-1:0]   frame_bytes;
	logic [rjp_pkg::ELAPSED_W-1:0] elapsed_ms;

	modport source (output valid, data_byte, frame_bytes, elapsed_ms, input ready);
	modport sink   (input valid, data_byte, frame_bytes, elapsed_ms, output ready);
endinterface

/* rtl/rjp_packet_if.sv */
// Valid/ready channel carrying packet bytes out of the packetizer.
// Depends on rjp_pkg for the field widths.
interface rjp_packet_if;
	logic                       valid;
	logic                       ready;
	logic [rjp_pkg::DATA_W-1:0] out_byte;
	logic                       is_payload;
	logic                       packet_end;

	modport source (output valid, out_byte, is_payload, packet_end, input ready);
	modport sink   (input valid, out_byte, is_payload, packet_end, output ready);
endinterface

/* rtl/rtp_jpeg_packetizer.sv */
// RTP/JPEG packetizer (RFC 2435 framing), top level.
// Depends on rjp_pkg, rjp_frame_if and rjp_packet_if.
//
// Each frame byte accepted leaves as one output byte in the next cycle when the
// output side is ready, so payload runs at one byte per cycle. The first byte of
// every fragment first waits for a setup step, in which the fragment length, marker
// and timestamp are settled, followed by 20 header bytes, or 24 with interleaving
// on, all leaving through the single output byte register; while they leave, the
// input register holds the byte and the frame channel is stalled. Configuration
// writes take effect at the edge at which cfg_write is high.
module rtp_jpeg_packetizer #(
	parameter int FRAGMENT_BYTES = rjp_pkg::FRAGMENT_BYTES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [2:0]                 cfg_index,
	input  logic [rjp_pkg::CFG_W-1:0]  cfg_data,
	rjp_frame_if.sink                  frame,
	rjp_packet_if.source               packet
);

	localparam int FLW = $clog2(FRAGMENT_BYTES + 1);
	localparam logic [FLW-1:0] FRAG_MAX = FLW'(FRAGMENT_BYTES);
	localparam int FW = rjp_pkg::FRAME_W;

	logic                   il_q;
	logic [7:0]             chan_q;
	logic [31:0]            ssrc_q;
	logic [7:0]             qual_q;
	logic [rjp_pkg::DIM_W-1:0] width_q;
	logic [rjp_pkg::DIM_W-1:0] height_q;

	logic                   v_s1;
	logic [7:0]             data_s1;
	logic [FW-1:0]          total_s1;
	logic [15:0]            elapsed_s1;

	logic [FW-1:0]          offset_q;
	logic [rjp_pkg::SEQ_W-1:0] seq_q;
	logic [rjp_pkg::TS_W-1:0]  ts_q;
	logic [FLW-1:0]         left_q;
	logic                   hdr_q;
	logic [rjp_pkg::HIDX_W-1:0] hidx_q;
	logic                   marker_q;
	logic [15:0]            plen_q;

	logic                   ov_q;
	logic [7:0]             obyte_q;
	logic                   opay_q;
	logic                   oend_q;

	logic [FW-1:0]          total;
	logic [FW-1:0]          off_eff;
	logic [FW-1:0]          remain;
	logic [FLW-1:0]         frag;
	logic [rjp_pkg::TS_W-1:0] ts_eff;
	logic                   out_free;
	logic                   setup;
	logic                   hdr_emit;
	logic                   pay_emit;
	logic [7:0]             hdr_byte;
	logic [FLW-1:0]         left_next;
	logic [FW-1:0]          off_next;

	assign total   = (total_s1 == '0) ? FW'(1) : total_s1;
	assign off_eff = (offset_q >= total) ? '0 : offset_q;
	assign remain  = total - off_eff;
	assign frag    = (remain < FW'(FRAGMENT_BYTES)) ? remain[FLW-1:0] : FRAG_MAX;
	assign ts_eff  = (off_eff == '0)
		? ts_q + rjp_pkg::TS_W'(elapsed_s1) * rjp_pkg::TS_W'(rjp_pkg::TS_PER_MS) : ts_q;

	assign out_free  = !ov_q || packet.ready;
	assign setup     = v_s1 && (left_q == '0) && !hdr_q;
	assign hdr_emit  = v_s1 && hdr_q && out_free;
	assign pay_emit  = v_s1 && !hdr_q && (left_q != '0) && out_free;
	assign left_next = left_q - FLW'(1);
	assign off_next  = offset_q + FW'(1);

	assign frame.ready = !v_s1 || pay_emit;

	assign packet.valid      = ov_q;
	assign packet.out_byte   = obyte_q;
	assign packet.is_payload = opay_q;
	assign packet.packet_end = oend_q;

	always_comb begin
		case (hidx_q)
			5'd0:  hdr_byte = rjp_pkg::IL_MAGIC;
			5'd1:  hdr_byte = chan_q;
			5'd2:  hdr_byte = plen_q[15:8];
			5'd3:  hdr_byte = plen_q[7:0];
			5'd4:  hdr_byte = rjp_pkg::RTP_VERSION;
			5'd5:  hdr_byte = rjp_pkg::RTP_PT_JPEG | (marker_q ? rjp_pkg::RTP_MARKER : 8'h00);
			5'd6:  hdr_byte = seq_q[15:8];
			5'd7:  hdr_byte = seq_q[7:0];
			5'd8:  hdr_byte = ts_q[31:24];
			5'd9:  hdr_byte = ts_q[23:16];
			5'd10: hdr_byte = ts_q[15:8];
			5'd11: hdr_byte = ts_q[7:0];
			5'd12: hdr_byte = ssrc_q[31:24];
			5'd13: hdr_byte = ssrc_q[23:16];
			5'd14: hdr_byte = ssrc_q[15:8];
			5'd15: hdr_byte = ssrc_q[7:0];
			5'd17: hdr_byte = offset_q[23:16];
			5'd18: hdr_byte = offset_q[15:8];
			5'd19: hdr_byte = offset_q[7:0];
			5'd21: hdr_byte = qual_q;
			5'd22: hdr_byte = width_q[10:3];
			5'd23: hdr_byte = height_q[10:3];
			default: hdr_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			il_q     <= 1'b0;
			chan_q   <= '0;
			ssrc_q   <= '0;
			qual_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				rjp_pkg::REG_INTERLEAVED: il_q     <= cfg_data[0];
				rjp_pkg::REG_CHANNEL:     chan_q   <= cfg_data[7:0];
				rjp_pkg::REG_SOURCE:      ssrc_q   <= cfg_data;
				rjp_pkg::REG_QUALITY:     qual_q   <= cfg_data[7:0];
				rjp_pkg::REG_WIDTH:       width_q  <= cfg_data[rjp_pkg::DIM_W-1:0];
				rjp_pkg::REG_HEIGHT:      height_q <= cfg_data[rjp_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (frame.ready) begin
			v_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			data_s1    <= frame.data_byte;
			total_s1   <= frame.frame_bytes;
			elapsed_s1 <= frame.elapsed_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			seq_q    <= '0;
			ts_q     <= '0;
			left_q   <= '0;
			hdr_q    <= 1'b0;
			hidx_q   <= rjp_pkg::HIDX_IL_FIRST;
			marker_q <= 1'b0;
			plen_q   <= '0;
		end else if (setup) begin
			offset_q <= off_eff;
			ts_q     <= ts_eff;
			left_q   <= frag;
			marker_q <= (off_eff + FW'(frag)) == total;
			plen_q   <= 16'(frag) + 16'(rjp_pkg::HDR_BYTES);
			hdr_q    <= 1'b1;
			hidx_q   <= il_q ? rjp_pkg::HIDX_IL_FIRST : rjp_pkg::HIDX_RTP_FIRST;
		end else if (hdr_emit) begin
			if (hidx_q == rjp_pkg::HIDX_LAST) begin
				hdr_q <= 1'b0;
			end else begin
				hidx_q <= hidx_q + 5'd1;
			end
		end else if (pay_emit) begin
			left_q <= left_next;
			if (left_next == '0) begin
				seq_q    <= seq_q + 16'd1;
				offset_q <= (off_next >= total) ? '0 : off_next;
			end else begin
				offset_q <= off_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_free) begin
			ov_q <= hdr_emit || pay_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_emit) begin
			obyte_q <= hdr_byte;
			opay_q  <= 1'b0;
			oend_q  <= 1'b0;
		end else if (pay_emit) begin
			obyte_q <= data_s1;
			opay_q  <= 1'b1;
			oend_q  <= left_next == '0;
		end
	end

endmodule

/* verif/rtp_jpeg_packetizer_tb.sv */
// Self-checking testbench for rtp_jpeg_packetizer: a directed table, then random frames.
// Depends on rjp_pkg, rjp_frame_if, rjp_packet_if and the RTL top level.
// Every output byte is compared field by field with a local model or with fixed headers.
module rtp_jpeg_packetizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int LONG_STALL   = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_ITEMS  = 31;

	typedef struct packed {
		logic [7:0] value;
		logic       payload;
		logic       last;
	} out_byte_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REG
	} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		logic [7:0]   data;
		logic [23:0]  length;
		logic [15:0]  elapsed;
		logic [2:0]   idx;
		logic [31:0]  val;
		bit           typed;
		logic [159:0] hdr;
		logic         last;
	} row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_write;
	logic [2:0]                cfg_index;
	logic [rjp_pkg::CFG_W-1:0] cfg_data;

	rjp_frame_if  frame();
	rjp_packet_if packet();

	rtp_jpeg_packetizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame     (frame),
		.packet    (packet)
	);

	logic        c_interleave = 1'b0;
	logic [7:0]  c_channel    = '0;
	logic [31:0] c_ssrc       = '0;
	logic [7:0]  c_quality    = '0;
	logic [10:0] c_width      = '0;
	logic [10:0] c_height     = '0;

	logic [23:0] p_offset = '0;
	logic [15:0] p_seq    = '0;
	logic [31:0] p_stamp  = '0;
	logic [10:0] p_left   = '0;

	out_byte_t fresh_bytes[$];
	out_byte_t bytes_due[$];
	row_t      plan[$];

	int          fail_count    = 0;
	int          result_count  = 0;
	int          cycle_count   = 0;
	int          send_gap_pct  = 0;
	int          recv_gap_pct  = 0;
	logic        stall_req     = 1'b0;
	logic [23:0] gen_len       = '0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[rtp_jpeg_packetizer] ERROR");
			$finish;
		end
	end

	task automatic mismatch(input string what);
		$display("mismatch at result %0d: %s", result_count, what);
		fail_count++;
	endtask

	function automatic void emit(input logic [7:0] v, input logic p, input logic l);
		fresh_bytes.push_back('{v, p, l});
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			rjp_pkg::REG_INTERLEAVED: c_interleave = val[0];
			rjp_pkg::REG_CHANNEL:     c_channel = val[7:0];
			rjp_pkg::REG_SOURCE:      c_ssrc = val;
			rjp_pkg::REG_QUALITY:     c_quality = val[7:0];
			rjp_pkg::REG_WIDTH:       c_width = val[10:0];
			rjp_pkg::REG_HEIGHT:      c_height = val[10:0];
			default: ;
		endcase
	endfunction

	function automatic void packetize(input logic [7:0] d, input logic [23:0] fb,
			input logic [15:0] el);
		logic [23:0] total;
		logic [23:0] remain;
		logic [10:0] frag;
		logic [15:0] plen;
		logic [7:0]  mark;
		fresh_bytes.delete();
		total = (fb == '0) ? 24'd1 : fb;
		if (p_left == '0) begin
			if (p_offset >= total)
				p_offset = '0;
			if (p_offset == '0)
				p_stamp = p_stamp + 32'(el) * 32'(rjp_pkg::TS_PER_MS);
			remain = total - p_offset;
			frag = (remain < rjp_pkg::FRAGMENT_BYTES) ? remain[10:0]
				: 11'(rjp_pkg::FRAGMENT_BYTES);
			mark = (p_offset + 24'(frag) == total) ? rjp_pkg::RTP_MARKER : 8'h00;
			plen = 16'(frag) + 16'(rjp_pkg::HDR_BYTES);
			if (c_interleave) begin
				emit(rjp_pkg::IL_MAGIC, 1'b0, 1'b0);
				emit(c_channel, 1'b0, 1'b0);
				emit(plen[15:8], 1'b0, 1'b0);
				emit(plen[7:0], 1'b0, 1'b0);
			end
			emit(rjp_pkg::RTP_VERSION, 1'b0, 1'b0);
			emit(rjp_pkg::RTP_PT_JPEG | mark, 1'b0, 1'b0);
			emit(p_seq[15:8], 1'b0, 1'b0);
			emit(p_seq[7:0], 1'b0, 1'b0);
			emit(p_stamp[31:24], 1'b0, 1'b0);
			emit(p_stamp[23:16], 1'b0, 1'b0);
			emit(p_stamp[15:8], 1'b0, 1'b0);
			emit(p_stamp[7:0], 1'b0, 1'b0);
			emit(c_ssrc[31:24], 1'b0, 1'b0);
			emit(c_ssrc[23:16], 1'b0, 1'b0);
			emit(c_ssrc[15:8], 1'b0, 1'b0);
			emit(c_ssrc[7:0], 1'b0, 1'b0);
			emit(8'h00, 1'b0, 1'b0);
			emit(p_offset[23:16], 1'b0, 1'b0);
			emit(p_offset[15:8], 1'b0, 1'b0);
			emit(p_offset[7:0], 1'b0, 1'b0);
			emit(8'h00, 1'b0, 1'b0);
			emit(c_quality, 1'b0, 1'b0);
			emit(c_width[10:3], 1'b0, 1'b0);
			emit(c_height[10:3], 1'b0, 1'b0);
			p_left = frag;
		end
		p_left = p_left - 11'd1;
		p_offset = p_offset + 24'd1;
		emit(d, 1'b1, p_left == '0);
		if (p_left == '0) begin
			p_seq = p_seq + 16'd1;
			if (p_offset >= total)
				p_offset = '0;
		end
	endfunction

	function automatic row_t item_row(input logic [7:0] d, input logic [23:0] fb,
			input logic [15:0] el);
		row_t r;
		r = '{kind: ROW_ITEM, data: d, length: fb, elapsed: el, idx: '0, val: '0,
			typed: 0, hdr: '0, last: 1'b0};
		return r;
	endfunction

	function automatic row_t typed_row(input logic [7:0] d, input logic [23:0] fb,
			input logic [15:0] el, input logic [159:0] hdr);
		row_t r;
		r = item_row(d, fb, el);
		r.typed = 1;
		r.hdr = hdr;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic row_t reg_row(input logic [2:0] idx, input logic [31:0] val);
		row_t r;
		r = item_row('0, '0, '0);
		r.kind = ROW_REG;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic logic [31:0] reg_max(input logic [2:0] idx);
		case (idx)
			rjp_pkg::REG_INTERLEAVED:                  return 32'h1;
			rjp_pkg::REG_CHANNEL, rjp_pkg::REG_QUALITY: return 32'hff;
			rjp_pkg::REG_WIDTH, rjp_pkg::REG_HEIGHT:    return 32'h7ff;
			default:                                    return 32'hffff_ffff;
		endcase
	endfunction

	task automatic offer(input logic [7:0] d, input logic [23:0] fb, input logic [15:0] el,
			input bit keep);
		while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			frame.valid <= 1'b0;
			@(posedge clk);
		end
		frame.valid <= 1'b1;
		frame.data_byte <= d;
		frame.frame_bytes <= fb;
		frame.elapsed_ms <= el;
		do
			@(posedge clk);
		while (!frame.ready);
		packetize(d, fb, el);
		if (keep)
			foreach (fresh_bytes[i])
				bytes_due.push_back(fresh_bytes[i]);
	endtask

	task automatic wait_idle();
		frame.valid <= 1'b0;
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_reg(idx, val);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic shuffle_regs();
		logic [31:0] v;
		for (int i = rjp_pkg::REG_INTERLEAVED; i <= rjp_pkg::REG_HEIGHT; i++) begin
			case ($urandom_range(0, 3))
				0:       v = '0;
				1:       v = reg_max(3'(i));
				default: v = $urandom & reg_max(3'(i));
			endcase
			write_reg(3'(i), v);
		end
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
	endtask

	task automatic random_item();
		logic [23:0] fb;
		if (p_left == '0) begin
			if (p_offset == '0 || $urandom_range(0, 5) == 0) begin
				gen_len = ($urandom_range(0, 19) == 0) ? 24'd0 : 24'($urandom_range(1, 12));
			end
			fb = gen_len;
		end else if (p_left == 11'd1) begin
			if ($urandom_range(0, 7) == 0)
				gen_len = p_offset + 24'($urandom_range(2, 5));
			fb = gen_len;
		end else begin
			fb = ($urandom_range(0, 3) == 0) ? 24'($urandom) : gen_len;
		end
		offer(8'($urandom), fb, 16'($urandom), 1);
	endtask

	initial begin : receiver
		int hold;
		bit stalled;
		hold = 0;
		stalled = 0;
		packet.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req && !stalled) begin
				stalled = 1;
				hold = LONG_STALL;
			end
			if (hold > 0) begin
				hold--;
				packet.ready <= 1'b0;
			end else begin
				packet.ready <= (recv_gap_pct == 0) || ($urandom_range(0, 99) >= recv_gap_pct);
			end
		end
	end

	always @(posedge clk) begin : monitor
		out_byte_t want;
		if (arst_n && packet.valid && packet.ready) begin
			if (bytes_due.size() == 0) begin
				mismatch($sformatf("unexpected byte %h", packet.out_byte));
			end else begin
				want = bytes_due.pop_front();
				if (packet.out_byte !== want.value)
					mismatch($sformatf("out_byte %h, want %h", packet.out_byte, want.value));
				if (packet.is_payload !== want.payload)
					mismatch($sformatf("is_payload %b, want %b", packet.is_payload,
						want.payload));
				if (packet.packet_end !== want.last)
					mismatch($sformatf("packet_end %b, want %b", packet.packet_end,
						want.last));
			end
			result_count++;
		end
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		frame.valid <= 1'b0;
		frame.data_byte <= '0;
		frame.frame_bytes <= '0;
		frame.elapsed_ms <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct <= 26;
		recv_gap_pct <= 63;
		@(posedge clk);

		// Two single-byte frames straight after reset, the second with a zero length.
		plan.push_back(typed_row(8'h00, 24'd1, 16'd0,
			160'h809a0000_00000000_00000000_00000000_00000000));
		plan.push_back(typed_row(8'hff, 24'd0, 16'd0,
			160'h809a0001_00000000_00000000_00000000_00000000));
		plan.push_back(item_row(8'h5a, 24'd1, 16'hffff));
		plan.push_back(reg_row(rjp_pkg::REG_INTERLEAVED, 32'h1));
		plan.push_back(reg_row(rjp_pkg::REG_CHANNEL, 32'hff));
		plan.push_back(reg_row(rjp_pkg::REG_SOURCE, 32'hffff_ffff));
		plan.push_back(reg_row(rjp_pkg::REG_QUALITY, 32'hff));
		plan.push_back(reg_row(rjp_pkg::REG_WIDTH, 32'h7ff));
		plan.push_back(reg_row(rjp_pkg::REG_HEIGHT, 32'h7ff));
		plan.push_back(reg_row(REG_SPARE_LO, 32'hffff_ffff));
		plan.push_back(reg_row(REG_SPARE_HI, 32'hffff_ffff));
		plan.push_back(item_row(8'ha5, 24'd3, 16'hffff));
		plan.push_back(item_row(8'h3c, 24'd3, 16'h0000));
		plan.push_back(item_row(8'hc3, 24'd3, 16'hffff));
		// The frame shrinks inside an open fragment, which still runs to its end.
		plan.push_back(item_row(8'h01, 24'd4, 16'd10));
		plan.push_back(item_row(8'h02, 24'd2, 16'd0));
		plan.push_back(item_row(8'h03, 24'd2, 16'd0));
		plan.push_back(item_row(8'h04, 24'd2, 16'd0));
		// The frame grows at a fragment end, then shrinks at the next fragment start.
		plan.push_back(item_row(8'h11, 24'd2, 16'd7));
		plan.push_back(item_row(8'h12, 24'd5, 16'd0));
		plan.push_back(item_row(8'h13, 24'd2, 16'd3));
		plan.push_back(item_row(8'h14, 24'd2, 16'd0));
		plan.push_back(reg_row(rjp_pkg::REG_INTERLEAVED, 32'h1));
		plan.push_back(reg_row(rjp_pkg::REG_CHANNEL, 32'h0));
		plan.push_back(reg_row(rjp_pkg::REG_SOURCE, 32'h8000_0001));
		plan.push_back(reg_row(rjp_pkg::REG_QUALITY, 32'h1));
		plan.push_back(reg_row(rjp_pkg::REG_WIDTH, 32'h7));
		plan.push_back(reg_row(rjp_pkg::REG_HEIGHT, 32'h8));
		plan.push_back(item_row(8'h80, 24'd1, 16'd1));
		plan.push_back(item_row(8'h7f, 24'd1, 16'd1));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				offer(plan[i].data, plan[i].length, plan[i].elapsed, !plan[i].typed);
				if (plan[i].typed) begin
					for (int b = 0; b < rjp_pkg::HDR_BYTES; b++)
						bytes_due.push_back('{plan[i].hdr[159 - 8 * b -: 8], 1'b0, 1'b0});
					bytes_due.push_back('{plan[i].data, 1'b1, plan[i].last});
				end
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			wait_idle();
			send_gap_pct <= (phase == 0) ? 26 : (phase == 1) ? 63 : 0;
			recv_gap_pct <= (phase == 0) ? 63 : (phase == 1) ? 26 : 0;
			shuffle_regs();
			if (phase == 0)
				stall_req <= 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item();
		end

		frame.valid <= 1'b0;
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[rtp_jpeg_packetizer] OK");
		else
			$display("[rtp_jpeg_packetizer] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/rjp_pkg.sv
rtl/rjp_frame_if.sv
rtl/rjp_packet_if.sv
rtl/rtp_jpeg_packetizer.sv
verif/rtp_jpeg_packetizer_tb.sv
